[sv/binary_image_thinning_core_assert.svh]
// Assertion macros shared by the thinning core.
`ifndef BINARY_IMAGE_THINNING_CORE_ASSERT_SVH
`define BINARY_IMAGE_THINNING_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BITN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BITN_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/bitn_pkg.sv]
`default_nettype none
package bitn_pkg;

   // Request modes.
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;

   // Register indexes.
   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;

   localparam logic [8:0] REGION_RESET = 9'd256;

   // Control of the neighbourhood window.
   typedef struct packed {
      logic clear;
      logic load;
      logic second;
   } win_ctrl_type;

   // Deletion test for the centre pixel. Each column holds top, middle and
   // bottom in bits 0, 1 and 2.
   function automatic logic thin_mark(input logic [2:0] lc, input logic [2:0] cc,
                                      input logic [2:0] rc, input logic second);
      logic [7:0] ring;
      logic [3:0] k;
      logic [3:0] trans;
      logic       e, n, w, s;
      logic       blocked;
      e = rc[1];
      n = cc[0];
      w = lc[1];
      s = cc[2];
      ring = {rc[2], cc[2], lc[2], lc[1], lc[0], cc[0], rc[0], rc[1]};
      k = 4'd0;
      trans = 4'd0;
      for (int i = 0; i < 8; i++) begin
         k = k + {3'd0, ring[i]};
         trans = trans + {3'd0, (!ring[i] && ring[(i + 1) % 8])};
      end
      if (second) begin
         blocked = (n & e & s) | (e & s & w);
      end else begin
         blocked = (e & n & w) | (n & s & w);
      end
      return cc[1] && (k >= 4'd2) && (k <= 4'd6) && (trans == 4'd1) && !blocked;
   endfunction

endpackage
`default_nettype wire

[sv/bitn_ram.sv]
`default_nettype none
module bitn_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic          wdata,
   input  wire logic [AW-1:0] raddr,
   output logic               rdata
);

   logic mem [DEPTH];
   logic rdata_ff;

   // One write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[sv/bitn_window.sv]
`default_nettype none
module bitn_window (
   input  wire logic                  clock,
   input  wire bitn_pkg::win_ctrl_type ctrl,
   input  wire logic [2:0]            col_in,
   output logic                       mark
);
   import bitn_pkg::*;

   logic [2:0] cen_ff;
   logic [2:0] rgt_ff;

   // Two stored columns; the incoming column completes the 3x3 window.
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         cen_ff <= 3'd0;
         rgt_ff <= 3'd0;
      end else if (ctrl.load) begin
         cen_ff <= rgt_ff;
         rgt_ff <= col_in;
      end
   end

   assign mark = thin_mark(cen_ff, rgt_ff, col_in, ctrl.second);

endmodule
`default_nettype wire

[sv/binary_image_thinning_core.sv]
// Bilevel image store with in-place parallel thinning.
// Requests are taken on req_* when start is high and busy is low.
// Mode write stores req_pixel_in at (req_row, req_col) if that lies inside;
// busy stays low, so writes may follow every cycle. Mode read returns the
// pixel on rsp_* through the RD state and the result registers. Mode run
// thins the region set by the rows and columns registers and returns the
// number of full iterations once a subpass deletes nothing.
// A run scans each subpass in raster order; each column position takes
// three reads of the single image port plus one evaluation. A deletion
// sweep, which reads each pixel's mark and then clears the pixel, follows
// whenever marks were set.
// Results are one-cycle strobes on rsp_valid; the receiver cannot stall.
// Register writes on csr_* are always ready and are meant for idle times.
// Reset clears the control state and sets the region to full size; the
// image is undefined until written and needs no clearing pass, and the
// mark store is written in full by each marking scan before it is read.
`default_nettype none
module binary_image_thinning_core #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_row,
   input  wire logic [7:0] req_col,
   input  wire logic       req_pixel_in,
   output logic            rsp_valid,
   output logic            rsp_result_kind,
   output logic            rsp_pixel_out,
   output logic [7:0]      rsp_pass_count,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_wdata
);
   import bitn_pkg::*;

`include "binary_image_thinning_core_assert.svh"

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int CCW   = $clog2(MAX_COLS + 1);

   typedef enum logic [1:0] {IDLE, RD, MARK, APPLY} state_type;

   state_type      state_ff;
   logic [8:0]     rows_ff, cols_ff;
   logic [RCW-1:0] nr_ff, r_ff;
   logic [CCW-1:0] nc_ff, j_ff;
   logic [1:0]     phase_ff;
   logic           second_ff, any_ff, vld_ff, inside_ff;
   logic [1:0]     near_ff;
   logic [7:0]     pass_ff, pass_inc;
   logic           rsp_valid_ff, rsp_kind_ff, rsp_pixel_ff;
   logic [7:0]     rsp_pass_ff;

   logic          img_we, img_wdata, img_rdata;
   logic [AW-1:0] img_waddr, img_raddr;
   logic          mrk_we, mrk_wdata, mrk_rdata;
   logic [AW-1:0] mrk_waddr, mrk_raddr;
   win_ctrl_type  win_ctrl;
   logic [2:0]    win_col;
   logic          win_mark;

   logic           accept, req_inside, scan_valid, row_last, col_last;
   logic [RCW-1:0] scan_row;
   logic [AW-1:0]  req_addr, scan_addr, cur_addr, left_addr;

   function automatic logic [AW-1:0] pix_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
      return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
   endfunction

   assign accept     = start && !busy;
   assign busy       = (state_ff != IDLE);
   assign csr_ready  = 1'b1;
   assign req_inside = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign req_addr   = pix_addr(RW'(req_row), CW'(req_col));
   assign pass_inc   = (pass_ff == 8'hFF) ? pass_ff : pass_ff + 8'd1;
   assign row_last   = ({1'b0, r_ff} + 1'b1) == {1'b0, nr_ff};

   // Row and validity of the neighbour read issued in the current phase.
   always_comb begin
      case (phase_ff)
         2'd0:    scan_row = r_ff - 1'b1;
         2'd1:    scan_row = r_ff;
         default: scan_row = r_ff + 1'b1;
      endcase
      case (phase_ff)
         2'd0:    scan_valid = (r_ff != '0) && (j_ff < nc_ff);
         2'd1:    scan_valid = (j_ff < nc_ff);
         default: scan_valid = !row_last && (j_ff < nc_ff);
      endcase
   end

   assign scan_addr = pix_addr(RW'(scan_row), CW'(j_ff));
   assign cur_addr  = pix_addr(RW'(r_ff), CW'(j_ff));
   assign left_addr = pix_addr(RW'(r_ff), CW'(j_ff - 1'b1));
   assign col_last  = (state_ff == MARK) ? (j_ff == nc_ff)
                                         : ({1'b0, j_ff} + 1'b1) == {1'b0, nc_ff};
   assign win_col   = {img_rdata & vld_ff, near_ff[1], near_ff[0]};

   // Memory port and window control.
   always_comb begin
      img_we    = 1'b0;
      img_waddr = req_addr;
      img_wdata = req_pixel_in;
      img_raddr = (state_ff == MARK) ? scan_addr : req_addr;
      mrk_we    = 1'b0;
      mrk_waddr = left_addr;
      mrk_wdata = win_mark;
      mrk_raddr = cur_addr;
      win_ctrl.clear  = (state_ff == MARK) && (phase_ff == 2'd0) && (j_ff == '0);
      win_ctrl.load   = (state_ff == MARK) && (phase_ff == 2'd3);
      win_ctrl.second = second_ff;
      if (state_ff == IDLE && accept && req_mode == MODE_WRITE && req_inside) begin
         img_we = 1'b1;
      end
      if (state_ff == MARK && phase_ff == 2'd3 && j_ff != '0) begin
         mrk_we = 1'b1;
      end
      if (state_ff == APPLY && phase_ff[0] && mrk_rdata) begin
         img_we    = 1'b1;
         img_waddr = cur_addr;
         img_wdata = 1'b0;
      end
   end

   bitn_ram #(.DEPTH(DEPTH), .AW(AW)) u_image (
      .clock(clock), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
      .raddr(img_raddr), .rdata(img_rdata)
   );

   bitn_ram #(.DEPTH(DEPTH), .AW(AW)) u_marks (
      .clock(clock), .we(mrk_we), .waddr(mrk_waddr), .wdata(mrk_wdata),
      .raddr(mrk_raddr), .rdata(mrk_rdata)
   );

   bitn_window u_window (
      .clock(clock), .ctrl(win_ctrl), .col_in(win_col), .mark(win_mark)
   );

   // Sequencer, registers and result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rows_ff      <= REGION_RESET;
         cols_ff      <= REGION_RESET;
         pass_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 2'd0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) begin
               rows_ff <= csr_wdata;
            end else if (csr_index == CSR_COLS) begin
               cols_ff <= csr_wdata;
            end
         end
         unique case (state_ff)
            IDLE: begin
               if (accept && req_mode == MODE_READ) begin
                  inside_ff <= req_inside;
                  state_ff  <= RD;
               end else if (accept && req_mode == MODE_RUN) begin
                  nr_ff     <= (32'(rows_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_ff);
                  nc_ff     <= (32'(cols_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_ff);
                  pass_ff   <= 8'd0;
                  r_ff      <= '0;
                  j_ff      <= '0;
                  phase_ff  <= 2'd0;
                  any_ff    <= 1'b0;
                  second_ff <= 1'b0;
                  if (rows_ff == 9'd0 || cols_ff == 9'd0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= 1'b1;
                     rsp_pixel_ff <= 1'b0;
                     rsp_pass_ff  <= 8'd0;
                  end else begin
                     state_ff <= MARK;
                  end
               end
            end
            RD: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= 1'b0;
               rsp_pixel_ff <= img_rdata & inside_ff;
               rsp_pass_ff  <= 8'd0;
               state_ff     <= IDLE;
            end
            MARK: begin
               vld_ff   <= scan_valid;
               phase_ff <= phase_ff + 2'd1;
               if (phase_ff == 2'd1) begin
                  near_ff[0] <= img_rdata & vld_ff;
               end
               if (phase_ff == 2'd2) begin
                  near_ff[1] <= img_rdata & vld_ff;
               end
               if (phase_ff == 2'd3) begin
                  if (j_ff != '0 && win_mark) begin
                     any_ff <= 1'b1;
                  end
                  if (!col_last) begin
                     j_ff <= j_ff + 1'b1;
                  end else begin
                     j_ff <= '0;
                     r_ff <= r_ff + 1'b1;
                     if (row_last) begin
                        r_ff     <= '0;
                        phase_ff <= 2'd0;
                        if (any_ff || (j_ff != '0 && win_mark)) begin
                           state_ff <= APPLY;
                        end else begin
                           state_ff     <= IDLE;
                           rsp_valid_ff <= 1'b1;
                           rsp_kind_ff  <= 1'b1;
                           rsp_pixel_ff <= 1'b0;
                           rsp_pass_ff  <= second_ff ? pass_inc : pass_ff;
                        end
                     end
                  end
               end
            end
            APPLY: begin
               phase_ff <= {1'b0, !phase_ff[0]};
               if (phase_ff[0]) begin
                  if (!col_last) begin
                     j_ff <= j_ff + 1'b1;
                  end else begin
                     j_ff <= '0;
                     r_ff <= r_ff + 1'b1;
                     if (row_last) begin
                        r_ff      <= '0;
                        phase_ff  <= 2'd0;
                        any_ff    <= 1'b0;
                        second_ff <= !second_ff;
                        state_ff  <= MARK;
                        if (second_ff) begin
                           pass_ff <= pass_inc;
                        end
                     end
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_pass_count  = rsp_pass_ff;

   // A read request is answered through the RD state with read data.
   `BITN_ASSERT(a_read_latency, clock, reset, (accept && req_mode == MODE_READ) |-> ##2 (rsp_valid && !rsp_result_kind), "read result missing")
   // Marks are written only by the marking scan.
   `BITN_NEVER(a_mark_write_scope, clock, reset, mrk_we && state_ff != MARK, "mark write outside scan")
   // The image port sees no write during the marking scan.
   `BITN_NEVER(a_no_write_in_run, clock, reset, img_we && state_ff == MARK, "image write during marking")

endmodule
`default_nettype wire
